/* rtl/core/blpl_pkg.sv */
// Shared types, constants and codes for the B-MAC low-power-listening controller.
package blpl_pkg;

    localparam int ANC_DEPTH = 16;
    localparam int ADDR_BITS = 16;

    localparam int ANC_AW = (ANC_DEPTH > 1) ? $clog2(ANC_DEPTH) : 1;
    localparam int FILL_W = $clog2(ANC_DEPTH + 1);

    localparam int FIELD_ADDR_W = 16;
    localparam int QC_W         = 7;
    localparam int CNT_W        = 5;
    localparam int IN_DATA_W    = 56;
    localparam int OUT_DATA_W   = 24;

    typedef logic [ADDR_BITS-1:0] t_addr;
    localparam t_addr BCAST_ADDR = '1;

    typedef enum logic [3:0] {
        ST_INIT        = 4'd0,
        ST_SLEEP       = 4'd1,
        ST_CCA         = 4'd2,
        ST_SEND_PRE    = 4'd3,
        ST_SEND_DATA   = 4'd4,
        ST_WAIT_TX     = 4'd5,
        ST_WAIT_ACK    = 4'd6,
        ST_WAIT_DATA   = 4'd7,
        ST_SEND_ACK    = 4'd8,
        ST_WAIT_ACK_TX = 4'd9
    } t_mac_state;

    typedef enum logic [3:0] {
        EV_START          = 4'd0,
        EV_WAKEUP         = 4'd1,
        EV_CCA_TIMEOUT    = 4'd2,
        EV_PREAMBLE       = 4'd3,
        EV_DATA           = 4'd4,
        EV_ACK            = 4'd5,
        EV_SEND_PREAMBLE  = 4'd6,
        EV_STOP_PREAMBLES = 4'd7,
        EV_RESEND         = 4'd8,
        EV_DATA_TX_OVER   = 4'd9,
        EV_ACK_TIMEOUT    = 4'd10,
        EV_DATA_TIMEOUT   = 4'd11,
        EV_SEND_ACK       = 4'd12,
        EV_ACK_TX_OVER    = 4'd13
    } t_event;

    typedef enum logic [1:0] {
        RADIO_NONE  = 2'd0,
        RADIO_SLEEP = 2'd1,
        RADIO_RX    = 2'd2,
        RADIO_TX    = 2'd3
    } t_radio;

    typedef enum logic [3:0] {
        TMR_NONE            = 4'd0,
        TMR_WAKE_RAND_CHECK = 4'd1,
        TMR_WAKE_SLOT       = 4'd2,
        TMR_WAKE_RAND_SLOT  = 4'd3,
        TMR_CCA_CHECK       = 4'd4,
        TMR_STOP_SLOT       = 4'd5,
        TMR_DATA_SLOT       = 4'd6,
        TMR_ACK_CHECK       = 4'd7,
        TMR_PRE_HALF        = 4'd8,
        TMR_REQUEUE         = 4'd9
    } t_timer;

    typedef enum logic [1:0] {
        CAN_NONE = 2'd0,
        CAN_CCA  = 2'd1,
        CAN_DATA = 2'd2,
        CAN_ACK  = 2'd3
    } t_cancel;

    typedef enum logic [1:0] {
        TX_NONE     = 2'd0,
        TX_PREAMBLE = 2'd1,
        TX_DATA     = 2'd2,
        TX_ACK      = 2'd3
    } t_tx;

    typedef enum logic [1:0] {
        OUT_NONE    = 2'd0,
        OUT_MATCH   = 2'd1,
        OUT_DROPPED = 2'd2
    } t_outcome;

    typedef enum logic [1:0] {
        ATT_KEEP,
        ATT_ONE,
        ATT_INC
    } t_att_op;

    typedef enum logic [1:0] {
        PEND_KEEP,
        PEND_HEAD,
        PEND_CLEAR
    } t_pend_op;

    typedef enum logic [1:0] {
        CFG_MY_ADDR  = 2'd0,
        CFG_USE_ACKS = 2'd1,
        CFG_MAX_ATT  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CT_IDLE,
        CT_EVAL,
        CT_SEARCH,
        CT_EMIT
    } t_ctrl;

    typedef enum logic {
        AS_IDLE,
        AS_SCAN
    } t_anc_state;

    typedef struct packed {
        t_mac_state nxt;
        t_radio     radio;
        t_timer     timer;
        t_cancel    cancel;
        t_tx        tx;
        logic       deliver;
        logic       pop;
        t_outcome   outcome;
        logic       unexpected;
        t_att_op    att_op;
        t_pend_op   pend_op;
        logic       anc_add;
    } t_dec;

endpackage

/* rtl/core/blpl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module blpl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/blpl_anc.sv */
// Ancestor set: sequential search with one comparator, append if absent.
module blpl_anc
    import blpl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_addr             i_key,
    output logic              o_done,
    output logic [FILL_W-1:0] o_fill
);

    t_anc_state        r_state, n_state;
    logic [FILL_W-1:0] r_idx, n_idx;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_cmp, n_cmp;
    t_addr             r_key;
    t_addr             rd_data;
    logic              found;
    logic              scan_end;
    logic              wr_en;

    blpl_ram #(
        .WIDTH (ADDR_BITS),
        .DEPTH (ANC_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_fill[ANC_AW-1:0]),
        .i_wdata (r_key),
        .i_raddr (r_idx[ANC_AW-1:0]),
        .o_rdata (rd_data)
    );

    // Read data is registered: rd_data holds entry r_idx-1, whose address was issued in the cycle before.
    assign found    = r_cmp && (rd_data == r_key);
    assign scan_end = !found && (r_idx == r_fill);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_cmp   = r_cmp;
        n_fill  = r_fill;
        wr_en   = 1'b0;
        o_done  = 1'b0;
        case (r_state)
            AS_IDLE: begin
                if (i_start) begin
                    n_state = AS_SCAN;
                    n_idx   = '0;
                    n_cmp   = 1'b0;
                end
            end
            AS_SCAN: begin
                if (found) begin
                    o_done  = 1'b1;
                    n_state = AS_IDLE;
                end else if (scan_end) begin
                    // drop the new source once the set is full
                    o_done  = 1'b1;
                    n_state = AS_IDLE;
                    if (r_fill < FILL_W'(ANC_DEPTH)) begin
                        wr_en  = 1'b1;
                        n_fill = r_fill + 1'b1;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_cmp = 1'b1;
                end
            end
            default: begin
                n_state = AS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= AS_IDLE;
            r_idx   <= '0;
            r_cmp   <= 1'b0;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cmp   <= n_cmp;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && (r_state == AS_IDLE)) begin
            r_key <= i_key;
        end
    end

    assign o_fill = r_fill;

endmodule

/* rtl/core/blpl_decode.sv */
// Event decode: next MAC state and the commands for one event.
module blpl_decode
    import blpl_pkg::*;
(
    input  t_mac_state         i_state,
    input  logic [3:0]         i_mode,
    input  t_addr              i_src,
    input  t_addr              i_dest,
    input  logic [QC_W-1:0]    i_qc,
    input  t_addr              i_me,
    input  logic               i_use_acks,
    input  logic [3:0]         i_max_att,
    input  logic [3:0]         i_attempt,
    input  t_addr              i_pending,
    output t_dec               o_dec
);

    logic remain_after_pop;
    logic remain_now;

    assign remain_after_pop = (i_qc > QC_W'(1));
    assign remain_now       = (i_qc != '0);

    always_comb begin
        t_dec d;
        logic bad;
        d.nxt        = i_state;
        d.radio      = RADIO_NONE;
        d.timer      = TMR_NONE;
        d.cancel     = CAN_NONE;
        d.tx         = TX_NONE;
        d.deliver    = 1'b0;
        d.pop        = 1'b0;
        d.outcome    = OUT_NONE;
        d.unexpected = 1'b0;
        d.att_op     = ATT_KEEP;
        d.pend_op    = PEND_KEEP;
        d.anc_add    = 1'b0;
        bad          = 1'b0;
        case (i_state)
            ST_INIT: begin
                if (i_mode == EV_START) begin
                    d.nxt   = ST_SLEEP;
                    d.radio = RADIO_SLEEP;
                    d.timer = TMR_WAKE_RAND_SLOT;
                end else begin
                    bad = 1'b1;
                end
            end
            ST_SLEEP: begin
                if (i_mode == EV_WAKEUP) begin
                    d.nxt   = ST_CCA;
                    d.radio = RADIO_RX;
                    d.timer = TMR_CCA_CHECK;
                end else begin
                    bad = 1'b1;
                end
            end
            ST_CCA: begin
                if (i_mode == EV_CCA_TIMEOUT) begin
                    if (remain_now) begin
                        d.nxt   = ST_SEND_PRE;
                        d.radio = RADIO_TX;
                        d.timer = TMR_STOP_SLOT;
                    end else begin
                        d.nxt   = ST_SLEEP;
                        d.radio = RADIO_SLEEP;
                        d.timer = TMR_WAKE_SLOT;
                    end
                end else if (i_mode == EV_PREAMBLE) begin
                    d.nxt    = ST_WAIT_DATA;
                    d.cancel = CAN_CCA;
                    d.timer  = TMR_DATA_SLOT;
                end else if (i_mode == EV_DATA) begin
                    // hand the frame back as a fresh event
                    d.nxt    = ST_WAIT_DATA;
                    d.cancel = CAN_CCA;
                    d.timer  = TMR_REQUEUE;
                end else if (i_mode != EV_ACK) begin
                    bad = 1'b1;
                end
            end
            ST_SEND_PRE: begin
                if (i_mode == EV_SEND_PREAMBLE) begin
                    d.tx    = TX_PREAMBLE;
                    d.timer = TMR_PRE_HALF;
                end else if (i_mode == EV_STOP_PREAMBLES) begin
                    d.nxt    = ST_SEND_DATA;
                    d.att_op = ATT_ONE;
                end else begin
                    bad = 1'b1;
                end
            end
            ST_SEND_DATA: begin
                if ((i_mode == EV_SEND_PREAMBLE) || (i_mode == EV_RESEND)) begin
                    d.tx      = TX_DATA;
                    d.pend_op = PEND_HEAD;
                    d.nxt     = ST_WAIT_TX;
                end else begin
                    bad = 1'b1;
                end
            end
            ST_WAIT_TX: begin
                if (i_mode == EV_DATA_TX_OVER) begin
                    if (i_use_acks && (i_pending != BCAST_ADDR)) begin
                        d.nxt   = ST_WAIT_ACK;
                        d.radio = RADIO_RX;
                        d.timer = TMR_ACK_CHECK;
                    end else begin
                        d.pop   = 1'b1;
                        d.nxt   = ST_SLEEP;
                        d.radio = RADIO_SLEEP;
                        d.timer = remain_after_pop ? TMR_WAKE_RAND_CHECK : TMR_WAKE_SLOT;
                    end
                end else begin
                    bad = 1'b1;
                end
            end
            ST_WAIT_ACK: begin
                if (i_mode == EV_ACK_TIMEOUT) begin
                    if (i_attempt < i_max_att) begin
                        d.att_op = ATT_INC;
                        d.nxt    = ST_SEND_PRE;
                        d.radio  = RADIO_TX;
                        d.timer  = TMR_STOP_SLOT;
                    end else begin
                        d.pop     = 1'b1;
                        d.nxt     = ST_SLEEP;
                        d.radio   = RADIO_SLEEP;
                        d.timer   = remain_after_pop ? TMR_WAKE_RAND_CHECK : TMR_WAKE_SLOT;
                        d.outcome = OUT_DROPPED;
                    end
                end else if (i_mode == EV_ACK) begin
                    // ignore an ack from anyone but the pending destination
                    if (i_src == i_pending) begin
                        d.pend_op = PEND_CLEAR;
                        d.cancel  = CAN_ACK;
                        d.pop     = 1'b1;
                        d.nxt     = ST_SLEEP;
                        d.radio   = RADIO_SLEEP;
                        d.timer   = remain_after_pop ? TMR_WAKE_RAND_CHECK : TMR_WAKE_SLOT;
                        d.outcome = OUT_MATCH;
                    end
                end else if ((i_mode != EV_PREAMBLE) && (i_mode != EV_DATA)) begin
                    bad = 1'b1;
                end
            end
            ST_WAIT_DATA: begin
                if (i_mode == EV_DATA) begin
                    d.anc_add = (i_dest == i_me);
                    d.deliver = (i_dest == i_me) || (i_dest == BCAST_ADDR);
                    d.cancel  = CAN_DATA;
                    if (i_use_acks && (i_dest == i_me)) begin
                        d.nxt   = ST_SEND_ACK;
                        d.radio = RADIO_TX;
                    end else begin
                        d.nxt   = ST_SLEEP;
                        d.radio = RADIO_SLEEP;
                        d.timer = remain_now ? TMR_WAKE_RAND_CHECK : TMR_WAKE_SLOT;
                    end
                end else if (i_mode == EV_DATA_TIMEOUT) begin
                    d.nxt   = ST_SLEEP;
                    d.radio = RADIO_SLEEP;
                    d.timer = remain_now ? TMR_WAKE_RAND_CHECK : TMR_WAKE_SLOT;
                end else if ((i_mode != EV_PREAMBLE) && (i_mode != EV_ACK)) begin
                    bad = 1'b1;
                end
            end
            ST_SEND_ACK: begin
                if (i_mode == EV_SEND_ACK) begin
                    d.tx  = TX_ACK;
                    d.nxt = ST_WAIT_ACK_TX;
                end else begin
                    bad = 1'b1;
                end
            end
            ST_WAIT_ACK_TX: begin
                if (i_mode == EV_ACK_TX_OVER) begin
                    d.nxt   = ST_SLEEP;
                    d.radio = RADIO_SLEEP;
                    d.timer = remain_now ? TMR_WAKE_RAND_CHECK : TMR_WAKE_SLOT;
                end else begin
                    bad = 1'b1;
                end
            end
            default: begin
                bad = 1'b1;
            end
        endcase

        // undefined event: hold the state and keep every command idle
        if (bad) begin
            d.nxt        = i_state;
            d.radio      = RADIO_NONE;
            d.timer      = TMR_NONE;
            d.cancel     = CAN_NONE;
            d.tx         = TX_NONE;
            d.deliver    = 1'b0;
            d.pop        = 1'b0;
            d.outcome    = OUT_NONE;
            d.unexpected = 1'b1;
            d.att_op     = ATT_KEEP;
            d.pend_op    = PEND_KEEP;
            d.anc_add    = 1'b0;
        end
        o_dec = d;
    end

endmodule

/* rtl/core/bmac_low_power_listening_fsm.sv */
// Top level: B-MAC low-power-listening controller, one result beat per event beat.
//
//  Channel   Dir  Signals                          Contents (lowest bit first)
//  s_axis    in   tvalid tready tdata[55:0] tuser  src, dest, queue_count, head_dest; mode
//  m_axis    out  tvalid tready tdata[23:0]        fsm_state ... unexpected_event
//  cfg       in   i_cfg_we i_cfg_idx i_cfg_data    my_mac_addr, use_mac_acks, max_tx_attempts
//
//  An event passes through the accept, decode and emit states; a data frame addressed to this
//  node also passes through a search state between decode and emit, the one-comparator scan
//  of the ancestor RAM, one entry a cycle.
//  s_axis_tready is high only in the accept state; a result beat waits in the output
//  register while the next event is taken and decoded.
//  Reset is synchronous, active low; the ancestor RAM is not cleared.
module bmac_low_power_listening_fsm
    import blpl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [15:0] src_addr, [31:16] dest_addr, [38:32] queue_count,
    // [54:39] head_dest_addr, [55] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [3:0] mode
    input  logic [3:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [3:0] fsm_state, [5:4] radio_cmd, [9:6] timer_req, [11:10] timer_cancel,
    // [13:12] tx_action, [14] deliver_up, [15] pop_queue, [17:16] ack_outcome,
    // [22:18] ancestor_count, [23] unexpected_event
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [15:0]           i_cfg_data
);

    t_ctrl             r_ctrl, n_ctrl;
    t_mac_state        r_mac_state;
    logic [3:0]        r_attempt;
    t_addr             r_pending;
    logic [15:0]       r_my_addr;
    logic              r_use_acks;
    logic [3:0]        r_max_att;
    logic              r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;

    logic [3:0]        r_mode;
    t_addr             r_src;
    t_addr             r_dest;
    logic [QC_W-1:0]   r_qc;
    t_addr             r_head;

    t_dec              dec;
    logic              anc_start;
    logic              anc_done;
    logic [FILL_W-1:0] anc_fill;
    logic [CNT_W-1:0]  anc_cnt;
    logic              emit;
    logic              accept;

    blpl_decode u_decode (
        .i_state    (r_mac_state),
        .i_mode     (r_mode),
        .i_src      (r_src),
        .i_dest     (r_dest),
        .i_qc       (r_qc),
        .i_me       (ADDR_BITS'(r_my_addr)),
        .i_use_acks (r_use_acks),
        .i_max_att  (r_max_att),
        .i_attempt  (r_attempt),
        .i_pending  (r_pending),
        .o_dec      (dec)
    );

    blpl_anc u_anc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (anc_start),
        .i_key   (r_src),
        .o_done  (anc_done),
        .o_fill  (anc_fill)
    );

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_ctrl == CT_IDLE);
    assign emit          = (r_ctrl == CT_EMIT) && (!r_m_valid || m_axis_tready);
    assign anc_cnt       = (int'(anc_fill) > 31) ? CNT_W'(31) : CNT_W'(anc_fill);

    always_comb begin
        n_ctrl    = r_ctrl;
        anc_start = 1'b0;
        case (r_ctrl)
            CT_IDLE: begin
                if (s_axis_tvalid) begin
                    n_ctrl = CT_EVAL;
                end
            end
            CT_EVAL: begin
                if (dec.anc_add) begin
                    anc_start = 1'b1;
                    n_ctrl    = CT_SEARCH;
                end else begin
                    n_ctrl = CT_EMIT;
                end
            end
            CT_SEARCH: begin
                if (anc_done) begin
                    n_ctrl = CT_EMIT;
                end
            end
            CT_EMIT: begin
                if (emit) begin
                    n_ctrl = CT_IDLE;
                end
            end
            default: begin
                n_ctrl = CT_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl      <= CT_IDLE;
            r_mac_state <= ST_INIT;
            r_attempt   <= '0;
            r_pending   <= BCAST_ADDR;
            r_m_valid   <= 1'b0;
        end else begin
            r_ctrl <= n_ctrl;
            if (emit) begin
                r_mac_state <= dec.nxt;
                case (dec.att_op)
                    ATT_ONE:  r_attempt <= 4'd1;
                    ATT_INC:  r_attempt <= r_attempt + 4'd1;
                    default:  r_attempt <= r_attempt;
                endcase
                case (dec.pend_op)
                    PEND_HEAD:  r_pending <= r_head;
                    PEND_CLEAR: r_pending <= BCAST_ADDR;
                    default:    r_pending <= r_pending;
                endcase
            end
            if (emit) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_addr  <= '0;
            r_use_acks <= 1'b1;
            r_max_att  <= 4'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MY_ADDR:  r_my_addr  <= i_cfg_data;
                CFG_USE_ACKS: r_use_acks <= i_cfg_data[0];
                CFG_MAX_ATT:  r_max_att  <= i_cfg_data[3:0];
                default:      r_max_att  <= r_max_att;
            endcase
        end
    end

    // hold the event beat for the whole of its processing
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= s_axis_tuser;
            r_src  <= ADDR_BITS'(s_axis_tdata[15:0]);
            r_dest <= ADDR_BITS'(s_axis_tdata[31:16]);
            r_qc   <= s_axis_tdata[38:32];
            r_head <= ADDR_BITS'(s_axis_tdata[54:39]);
        end
        if (emit) begin
            r_m_data <= {dec.unexpected, anc_cnt, dec.outcome, dec.pop, dec.deliver,
                         dec.tx, dec.cancel, dec.timer, dec.radio, dec.nxt};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule
